// ===== hdl/rps_pkg.sv =====
// Shared types and constants of the relay pulse sequencer.
package rps_pkg;

    localparam int ENTRY_BITS  = 4;
    localparam int TABLE_DEPTH = 2 ** ENTRY_BITS;
    localparam int TIME_BITS   = 24;
    localparam int PIN_BITS    = 8;

    // command codes of an input item
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // relay drive codes
    localparam logic [1:0] DRV_NONE = 2'd0;
    localparam logic [1:0] DRV_HIGH = 2'd1;
    localparam logic [1:0] DRV_LOW  = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_CHANGED = 2'd2;
    localparam logic [1:0] EV_ENDED   = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [ENTRY_BITS-1:0] entry_index;
        logic [PIN_BITS-1:0]   entry_pin;
        logic [TIME_BITS-1:0]  entry_on_ms;
        logic [TIME_BITS-1:0]  entry_off_ms;
        logic [ENTRY_BITS-1:0] entry_next;
        logic                  entry_is_last;
    } rps_item_t;

    typedef struct packed {
        logic [1:0]            relay_drive;
        logic [PIN_BITS-1:0]   relay_pin;
        logic [1:0]            event_code;
        logic [ENTRY_BITS-1:0] event_entry;
        logic                  start_accepted;
        logic                  busy_res;
    } rps_result_t;

    // one table row
    typedef struct packed {
        logic [PIN_BITS-1:0]   pin;
        logic [TIME_BITS-1:0]  on_ms;
        logic [TIME_BITS-1:0]  off_ms;
        logic [ENTRY_BITS-1:0] next;
        logic                  is_last;
    } rps_entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } rps_ctrl_t;

endpackage

// ===== hdl/rps_ctrl.sv =====
// Controller state machine of the relay pulse sequencer.
module rps_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output rps_pkg::rps_ctrl_t   ctrl
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg == ST_EXEC);
    assign ctrl.capture = start && (state_reg == ST_IDLE);
    assign ctrl.execute = (state_reg == ST_EXEC);

`ifndef SYNTHESIS
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> !ctrl.execute)
        else $error("execute held longer than one cycle");
    a_capture_leads_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> ctrl.execute)
        else $error("captured transfer not executed");
    a_exec_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |-> $past(ctrl.capture))
        else $error("execute without captured transfer");
`endif

endmodule

// ===== hdl/rps_datapath.sv =====
// Datapath of the relay pulse sequencer: entry table, phase state and result register.
module rps_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rps_pkg::rps_ctrl_t    ctrl,
    input  rps_pkg::rps_item_t    item,
    output logic                  done,
    output rps_pkg::rps_result_t  result
);

    typedef enum logic [2:0]
    {
        PH_SWITCH_ON = 3'b001,
        PH_ON_HOLD   = 3'b010,
        PH_OFF_HOLD  = 3'b100
    } phase_t;

    rps_pkg::rps_entry_t table_mem [rps_pkg::TABLE_DEPTH];

    rps_pkg::rps_item_t   item_reg;
    rps_pkg::rps_entry_t  rd_reg;
    rps_pkg::rps_result_t result_reg;
    rps_pkg::rps_result_t result_next;
    logic                 done_reg;

    logic                                running_reg;
    logic                                running_next;
    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [rps_pkg::ENTRY_BITS-1:0]      cur_reg;
    logic [rps_pkg::ENTRY_BITS-1:0]      cur_next;
    logic [rps_pkg::ENTRY_BITS-1:0]      first_reg;
    logic [rps_pkg::ENTRY_BITS-1:0]      first_next;
    logic [rps_pkg::TIME_BITS-1:0]       elapsed_reg;
    logic [rps_pkg::TIME_BITS-1:0]       elapsed_next;
    logic [rps_pkg::TIME_BITS-1:0]       elapsed_inc;

    // table: one write port, one registered read port at the current entry
    always_ff @(posedge clk)
    begin
        if (ctrl.execute && (item_reg.cmd == rps_pkg::CMD_WRITE))
        begin
            table_mem[item_reg.entry_index] <= '{pin:     item_reg.entry_pin,
                                                on_ms:   item_reg.entry_on_ms,
                                                off_ms:  item_reg.entry_off_ms,
                                                next:    item_reg.entry_next,
                                                is_last: item_reg.entry_is_last};
        end
        rd_reg <= table_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= item;
        end
        if (ctrl.execute)
        begin
            result_reg <= result_next;
        end
    end

    // saturating millisecond count
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg
                                             : elapsed_reg + rps_pkg::TIME_BITS'(1);

    always_comb
    begin
        running_next = running_reg;
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        elapsed_next = elapsed_reg;
        result_next  = '0;

        unique case (item_reg.cmd)
            rps_pkg::CMD_TICK:
            begin
                if (running_reg)
                begin
                    unique case (phase_reg)
                        PH_SWITCH_ON:
                        begin
                            result_next.relay_drive = rps_pkg::DRV_HIGH;
                            result_next.relay_pin   = rd_reg.pin;
                            elapsed_next            = '0;
                            phase_next              = PH_ON_HOLD;
                        end
                        PH_ON_HOLD:
                        begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc >= rd_reg.on_ms)
                            begin
                                result_next.relay_drive = rps_pkg::DRV_LOW;
                                result_next.relay_pin   = rd_reg.pin;
                                elapsed_next            = '0;
                                phase_next              = PH_OFF_HOLD;
                            end
                        end
                        default:
                        begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc >= rd_reg.off_ms)
                            begin
                                elapsed_next = '0;
                                phase_next   = PH_SWITCH_ON;
                                if (rd_reg.is_last)
                                begin
                                    running_next            = 1'b0;
                                    result_next.event_code  = rps_pkg::EV_ENDED;
                                    result_next.event_entry = first_reg;
                                end
                                else
                                begin
                                    cur_next                = rd_reg.next;
                                    result_next.event_code  = rps_pkg::EV_CHANGED;
                                    result_next.event_entry = rd_reg.next;
                                end
                            end
                        end
                    endcase
                end
            end
            rps_pkg::CMD_START:
            begin
                if (!running_reg)
                begin
                    running_next               = 1'b1;
                    first_next                 = item_reg.entry_index;
                    cur_next                   = item_reg.entry_index;
                    phase_next                 = PH_SWITCH_ON;
                    elapsed_next               = '0;
                    result_next.start_accepted = 1'b1;
                    result_next.event_code     = rps_pkg::EV_STARTED;
                    result_next.event_entry    = item_reg.entry_index;
                end
            end
            default:
            begin
                // table write is handled by the memory port; unused code does nothing
            end
        endcase

        result_next.busy_res = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= PH_SWITCH_ON;
            cur_reg     <= '0;
            first_reg   <= '0;
            elapsed_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.execute;
            if (ctrl.execute)
            begin
                running_reg <= running_next;
                phase_reg   <= phase_next;
                cur_reg     <= cur_next;
                first_reg   <= first_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctrl.execute))
        else $error("result strobe without executed transfer");
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (phase_reg == PH_SWITCH_ON) && (elapsed_reg == '0))
        else $error("phase state left over while idle");
    a_busy_res_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.busy_res == running_reg))
        else $error("busy_res disagrees with running state");
    a_accept_event: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.start_accepted) |->
            (result.event_code == rps_pkg::EV_STARTED) && result.busy_res)
        else $error("accepted start without started event");
`endif

endmodule

// ===== hdl/relay_pulse_sequencer_core.sv =====
// Top level of the relay pulse sequencer: controller plus datapath.
// A transfer taken at a start edge executes in the next cycle and its result
// strobes on done in the cycle after that. A new item is taken only while idle, so
// none is taken while busy; busy is high for the single execute cycle.
// Reset: rst_n clears the sequence state to idle at once; the table is undefined until written.
// Results cannot be stalled: done is high for exactly one cycle per item.
module relay_pulse_sequencer_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rps_pkg::rps_item_t    item,
    output logic                  busy,
    output logic                  done,
    output rps_pkg::rps_result_t  result
);

    // capture / execute commands from the controller to the datapath
    rps_pkg::rps_ctrl_t ctrl;

    // Accept a transfer while idle, then execute it for one cycle.
    rps_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Hold the table and phase state; advance the phase machine on ticks,
    // load entries on writes, begin sequences on starts, and drive the result.
    rps_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .done   (done),
        .result (result)
    );

endmodule
